/* rtl/tnafq_pkg.sv */
// ----------------------------------------------------------------------------
// tnafq_pkg
// Shared types and constants of the transit-node arc-flag query block:
// word layouts, item kinds and the control group of the minimum unit.
// ----------------------------------------------------------------------------
package tnafq_pkg;

  localparam int unsigned DIST_W   = 32;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned REGION_W = 5;

  localparam logic [DIST_W-1:0] ALL_ONES = '1;

  // Item kinds carried in the input word.
  typedef enum logic [1:0] {
    KIND_TABLE_WR = 2'd0,
    KIND_FWD      = 2'd1,
    KIND_BWD      = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_e;

  // Input word.
  typedef struct packed {
    kind_e                kind;
    logic [IDX_W-1:0]     transit_row;
    logic [IDX_W-1:0]     transit_col;
    logic [DIST_W-1:0]    distance;
    logic [DIST_W-1:0]    region_flags;
    logic [REGION_W-1:0]  source_region;
    logic [REGION_W-1:0]  target_region;
  } tnafq_in_t;

  // Result word.
  typedef struct packed {
    logic [DIST_W-1:0] shortest_distance;
    logic              found;
    logic              list_overflow;
  } tnafq_out_t;

  // One access list entry.
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] flags;
  } access_entry_t;

  // Control of the minimum unit.
  typedef struct packed {
    logic start;   // new query: reload the running minimum
    logic en;      // a valid pair is present at the unit inputs
  } minu_ctrl_t;

endpackage

/* rtl/transit_node_arc_flag_query.sv */
// ----------------------------------------------------------------------------
// transit_node_arc_flag_query
// Transit-node routing query with arc flags. Loads fill a distance table
// and two access lists; a query walks all forward/backward pairs through
// one shared add and compare unit and returns the least route length.
//
//   channel  signals                          word
//   -------  -------------------------------  -----------
//   input    in_valid_i  in_ready_o  in_data_i    tnafq_in_t
//   output   out_valid_o out_ready_i out_data_o   tnafq_out_t
//
// A table write or access entry needs no further work after it is accepted.
// A query keeps the input closed from its accept cycle until its word is
// handed to the output register: one pair enters the read pipeline per cycle
// (list read, table read, add and compare), then the pipeline drains and the
// word is loaded into the output register. A query over an empty list skips
// the walk and the drain.
// Reset clears the list fill counts, the overflow mark and the control; the
// memories hold no reset value. A stalled output word holds the query in its
// final cycle; loads are still taken while a word waits in the output register.
// ----------------------------------------------------------------------------
module transit_node_arc_flag_query
  import tnafq_pkg::*;
#(
  parameter int unsigned MAX_TRANSIT  = 256,
  parameter int unsigned MAX_ACCESS   = 16,
  parameter int unsigned REGION_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tnafq_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tnafq_out_t  out_data_o
);

  localparam int unsigned TAB_DEPTH = MAX_TRANSIT * MAX_TRANSIT;
  localparam int unsigned TAB_AW    = $clog2(TAB_DEPTH);
  localparam int unsigned MW        = TAB_AW + IDX_W;
  localparam int unsigned AIW       = (MAX_ACCESS > 1) ? $clog2(MAX_ACCESS) : 1;
  localparam int unsigned CW        = $clog2(MAX_ACCESS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e              state_d, state_q;
  logic [CW-1:0]       fcnt_d, fcnt_q, bcnt_d, bcnt_q;
  logic                ovf_d, ovf_q;
  logic [AIW-1:0]      i_d, i_q, j_d, j_q;
  logic [REGION_W-1:0] src_q, tgt_q;
  logic                s1_v_d, s1_v_q, s2_v_d, s2_v_q;
  logic [DIST_W:0]     acc_sum_q;
  logic                out_valid_d, out_valid_q;
  tnafq_out_t          out_q;

  logic                in_acc, out_load, last_i, last_j;
  logic                fwd_full, bwd_full;
  logic                tab_wr_en, fwd_wr_en, bwd_wr_en, pair_ok;
  logic [MW-1:0]       tab_wr_wide, tab_rd_wide;
  access_entry_t       in_entry, fwd_rd, bwd_rd;
  logic [DIST_W-1:0]   mid, best;
  logic                found;
  minu_ctrl_t          minu_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign fwd_full = (fcnt_q == CW'(MAX_ACCESS));
  assign bwd_full = (bcnt_q == CW'(MAX_ACCESS));

  // Load decode.
  always_comb begin
    tab_wr_en = in_acc && (in_data_i.kind == KIND_TABLE_WR)
                && (MW'(in_data_i.transit_row) < MW'(MAX_TRANSIT))
                && (MW'(in_data_i.transit_col) < MW'(MAX_TRANSIT));
    fwd_wr_en = in_acc && (in_data_i.kind == KIND_FWD) && !fwd_full;
    bwd_wr_en = in_acc && (in_data_i.kind == KIND_BWD) && !bwd_full;
    in_entry.index    = in_data_i.transit_row;
    in_entry.distance = in_data_i.distance;
    in_entry.flags    = in_data_i.region_flags;
    tab_wr_wide = MW'(in_data_i.transit_row) * MW'(MAX_TRANSIT)
                  + MW'(in_data_i.transit_col);
  end

  tnafq_dist_table #(
    .DEPTH  (TAB_DEPTH),
    .ADDR_W (TAB_AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tab_wr_en),
    .wr_addr_i (tab_wr_wide[TAB_AW-1:0]),
    .wr_data_i (in_data_i.distance),
    .rd_addr_i (tab_rd_wide[TAB_AW-1:0]),
    .rd_data_o (mid)
  );

  tnafq_access_list #(
    .DEPTH  (MAX_ACCESS),
    .ADDR_W (AIW)
  ) u_fwd_list (
    .clk_i      (clk_i),
    .wr_en_i    (fwd_wr_en),
    .wr_addr_i  (fcnt_q[AIW-1:0]),
    .wr_entry_i (in_entry),
    .rd_addr_i  (i_q),
    .rd_entry_o (fwd_rd)
  );

  tnafq_access_list #(
    .DEPTH  (MAX_ACCESS),
    .ADDR_W (AIW)
  ) u_bwd_list (
    .clk_i      (clk_i),
    .wr_en_i    (bwd_wr_en),
    .wr_addr_i  (bcnt_q[AIW-1:0]),
    .wr_entry_i (in_entry),
    .rd_addr_i  (j_q),
    .rd_entry_o (bwd_rd)
  );

  // Pair check on the list read data; the table address follows from it.
  always_comb begin
    pair_ok = (32'(tgt_q) < REGION_COUNT) && fwd_rd.flags[tgt_q]
              && (32'(src_q) < REGION_COUNT) && bwd_rd.flags[src_q]
              && (MW'(fwd_rd.index) < MW'(MAX_TRANSIT))
              && (MW'(bwd_rd.index) < MW'(MAX_TRANSIT));
    tab_rd_wide = MW'(fwd_rd.index) * MW'(MAX_TRANSIT) + MW'(bwd_rd.index);
    s2_v_d = s1_v_q && pair_ok;
  end

  // Access distance sum, registered alongside the table read data.
  always_ff @(posedge clk_i) begin
    acc_sum_q <= (DIST_W+1)'(fwd_rd.distance) + (DIST_W+1)'(bwd_rd.distance);
  end

  // An all-ones table entry marks an unreachable pair.
  always_comb begin
    minu_ctrl.start = in_acc && (in_data_i.kind == KIND_QUERY);
    minu_ctrl.en    = s2_v_q && (mid != ALL_ONES);
  end

  tnafq_min_unit u_min (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (minu_ctrl),
    .access_sum_i (acc_sum_q),
    .mid_i        (mid),
    .best_o       (best),
    .found_o      (found)
  );

  // Pair walk ends.
  assign last_j = (CW'(j_q) + CW'(1)) == bcnt_q;
  assign last_i = (CW'(i_q) + CW'(1)) == fcnt_q;

  // Sequencer, fill counts and output register control.
  always_comb begin
    state_d     = state_q;
    fcnt_d      = fcnt_q;
    bcnt_d      = bcnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    s1_v_d      = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.kind)
            KIND_FWD: begin
              if (fwd_full) begin
                ovf_d = 1'b1;
              end else begin
                fcnt_d = fcnt_q + CW'(1);
              end
            end
            KIND_BWD: begin
              if (bwd_full) begin
                ovf_d = 1'b1;
              end else begin
                bcnt_d = bcnt_q + CW'(1);
              end
            end
            KIND_QUERY: begin
              i_d = '0;
              j_d = '0;
              if ((fcnt_q == '0) || (bcnt_q == '0)) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        s1_v_d = 1'b1;
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + AIW'(1);
          end
        end else begin
          j_d = j_q + AIW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          fcnt_d      = '0;
          bcnt_d      = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fcnt_q      <= '0;
      bcnt_q      <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcnt_q      <= fcnt_d;
      bcnt_q      <= bcnt_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Query regions and the output word.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.kind == KIND_QUERY)) begin
      src_q <= in_data_i.source_region;
      tgt_q <= in_data_i.target_region;
    end
    if (out_load) begin
      out_q.shortest_distance <= best;
      out_q.found             <= found;
      out_q.list_overflow     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A found route is always shorter than the unreachable mark.
  a_found_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.shortest_distance != ALL_ONES))
    else $error("found result carries the unreachable distance");

  // Fill counts stay within the list capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcnt_q <= CW'(MAX_ACCESS)) && (bcnt_q <= CW'(MAX_ACCESS)))
    else $error("access list fill count beyond capacity");

  // The pair walk only runs over two non-empty lists.
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((fcnt_q != '0) && (bcnt_q != '0)))
    else $error("pair walk over an empty list");

  // A pair reaches the minimum unit only in the cycle after its list read.
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("table stage valid without a preceding list read");

  // The result word is loaded only after the pipeline has drained.
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!s1_v_q && !s2_v_q))
    else $error("result loaded while pairs are still in flight");
`endif

endmodule

/* rtl/tnafq_access_list.sv */
// ----------------------------------------------------------------------------
// tnafq_access_list
// Access entry memory for one direction: one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module tnafq_access_list
  import tnafq_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  access_entry_t        wr_entry_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output access_entry_t        rd_entry_o
);

  access_entry_t mem_q [DEPTH];
  access_entry_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_q;

endmodule

/* rtl/tnafq_dist_table.sv */
// ----------------------------------------------------------------------------
// tnafq_dist_table
// Transit-to-transit distance memory, one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module tnafq_dist_table
  import tnafq_pkg::*;
#(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  logic [DIST_W-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output logic [DIST_W-1:0]  rd_data_o
);

  logic [DIST_W-1:0] mem_q [DEPTH];
  logic [DIST_W-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/tnafq_min_unit.sv */
// ----------------------------------------------------------------------------
// tnafq_min_unit
// Shared add and compare unit: adds the table distance to the access
// distance sum, saturates, and keeps the running minimum of a query.
// ----------------------------------------------------------------------------
module tnafq_min_unit
  import tnafq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  minu_ctrl_t         ctrl_i,
  input  logic [DIST_W:0]    access_sum_i,
  input  logic [DIST_W-1:0]  mid_i,
  output logic [DIST_W-1:0]  best_o,
  output logic               found_o
);

  logic [DIST_W+1:0] sum_wide;
  logic [DIST_W-1:0] sum_sat;
  logic              better;
  logic [DIST_W-1:0] best_d, best_q;
  logic              found_d, found_q;

  // Wide sum, clamped to all ones on overflow.
  always_comb begin
    sum_wide = (DIST_W+2)'(access_sum_i) + (DIST_W+2)'(mid_i);
    sum_sat  = (|sum_wide[DIST_W+1:DIST_W]) ? ALL_ONES : sum_wide[DIST_W-1:0];
    better   = sum_sat < best_q;
  end

  // Running minimum; a clamped sum can never be strictly lower.
  always_comb begin
    best_d  = best_q;
    found_d = found_q;
    priority if (ctrl_i.start) begin
      best_d  = ALL_ONES;
      found_d = 1'b0;
    end else if (ctrl_i.en && better) begin
      best_d  = sum_sat;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= ALL_ONES;
      found_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      found_q <= found_d;
    end
  end

  assign best_o  = best_q;
  assign found_o = found_q;

endmodule

/* sim/tb_transit_node_arc_flag_query.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transit_node_arc_flag_query
// Self-checking bench for the transit-node arc-flag query block. Table
// writes, access entries and queries are driven over the input channel with
// random gaps. A scoreboard keeps its own copy of the distance table and the
// two access lists and works out the answer of each accepted query. Result
// words are checked in order under random output stalls. Before every query
// the bench writes any table entry that the loaded lists could reach, so no
// unwritten entry is ever read.
// ----------------------------------------------------------------------------

import tnafq_pkg::*;

localparam int unsigned MAX_TRANSIT  = 256;
localparam int unsigned MAX_ACCESS   = 16;
localparam int unsigned REGION_COUNT = 32;
localparam int unsigned TABLE_DEPTH  = MAX_TRANSIT * MAX_TRANSIT;

// Scoreboard: mirrors the block state and queues the expected answers.
class route_scoreboard;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [DIST_W-1:0] hop_table [TABLE_DEPTH];
  bit                hop_known [TABLE_DEPTH];
  access_entry_t     fwd_list  [MAX_ACCESS];
  access_entry_t     bwd_list  [MAX_ACCESS];
  int unsigned       fwd_count;
  int unsigned       bwd_count;
  bit                dropped;
  tnafq_out_t        expected_routes [$];

  int unsigned words_taken;
  int unsigned routes_checked;
  int unsigned routes_found;
  int unsigned routes_overflowed;
  int unsigned mismatches;

  function int unsigned slot(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return a * MAX_TRANSIT + b;
  endfunction

  function bit known(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return hop_known[slot(a, b)];
  endfunction

  // Regions past the configured count are never flagged.
  function bit flagged(logic [DIST_W-1:0] flags, logic [REGION_W-1:0] region);
    return (region < REGION_COUNT) && flags[region];
  endfunction

  function int unsigned pending();
    return expected_routes.size();
  endfunction

  // Walk every forward/backward pair and keep the least saturated sum.
  function tnafq_out_t predict_route(logic [REGION_W-1:0] src, logic [REGION_W-1:0] tgt);
    tnafq_out_t        r;
    logic [DIST_W-1:0] mid;
    logic [DIST_W+1:0] sum;
    logic [DIST_W-1:0] capped;
    r.shortest_distance = ALL_ONES;
    r.found             = 1'b0;
    r.list_overflow     = dropped;
    for (int i = 0; i < fwd_count; i++) begin
      if (flagged(fwd_list[i].flags, tgt)) begin
        for (int j = 0; j < bwd_count; j++) begin
          if (flagged(bwd_list[j].flags, src) && fwd_list[i].index < MAX_TRANSIT &&
              bwd_list[j].index < MAX_TRANSIT) begin
            mid = hop_table[slot(fwd_list[i].index, bwd_list[j].index)];
            if (mid != ALL_ONES) begin
              sum = {2'b00, fwd_list[i].distance} + {2'b00, mid} +
                    {2'b00, bwd_list[j].distance};
              capped = (sum > {2'b00, ALL_ONES}) ? ALL_ONES : sum[DIST_W-1:0];
              if (capped < r.shortest_distance) begin
                r.shortest_distance = capped;
                r.found             = 1'b1;
              end
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Note an accepted input word.
  function void take_word(tnafq_in_t w);
    access_entry_t e;
    words_taken++;
    e.index    = w.transit_row;
    e.distance = w.distance;
    e.flags    = w.region_flags;
    case (w.kind)
      KIND_TABLE_WR: begin
        if (w.transit_row < MAX_TRANSIT && w.transit_col < MAX_TRANSIT) begin
          hop_table[slot(w.transit_row, w.transit_col)] = w.distance;
          hop_known[slot(w.transit_row, w.transit_col)] = 1'b1;
        end
      end
      KIND_FWD: begin
        if (fwd_count >= MAX_ACCESS) begin
          dropped = 1'b1;
        end else begin
          fwd_list[fwd_count] = e;
          fwd_count++;
        end
      end
      KIND_BWD: begin
        if (bwd_count >= MAX_ACCESS) begin
          dropped = 1'b1;
        end else begin
          bwd_list[bwd_count] = e;
          bwd_count++;
        end
      end
      default: begin
        expected_routes = {expected_routes,
                           predict_route(w.source_region, w.target_region)};
        fwd_count = 0;
        bwd_count = 0;
        dropped   = 1'b0;
      end
    endcase
  endfunction

  // Compare a result word with the oldest expected answer.
  function void check_route(tnafq_out_t got);
    tnafq_out_t want;
    if (expected_routes.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] unexpected result word: distance %h found %b overflow %b",
                 $time, got.shortest_distance, got.found, got.list_overflow);
      return;
    end
    want = expected_routes.pop_front();
    routes_checked++;
    if (want.found) routes_found++;
    if (want.list_overflow) routes_overflowed++;
    if (got.shortest_distance !== want.shortest_distance || got.found !== want.found ||
        got.list_overflow !== want.list_overflow) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] result %0d: expected distance %h found %b overflow %b, got %h %b %b",
                 $time, routes_checked, want.shortest_distance, want.found,
                 want.list_overflow, got.shortest_distance, got.found, got.list_overflow);
    end
  endfunction
endclass

module tb_transit_node_arc_flag_query;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned TOTAL_WORDS    = 1700;
  localparam int unsigned MAX_WAIT       = 13;
  // The longest query walks 16 x 16 pairs.
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOT_NODES      = 12;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  tnafq_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tnafq_out_t out_data;

  route_scoreboard  routes = new;
  int unsigned      idle_cycles = 0;
  int unsigned      stall_left  = 0;
  bit               send_calm   = 1'b0;
  bit               recv_calm   = 1'b0;
  logic [IDX_W-1:0] hot_pool [HOT_NODES];

  transit_node_arc_flag_query #(
    .MAX_TRANSIT  (MAX_TRANSIT),
    .MAX_ACCESS   (MAX_ACCESS),
    .REGION_COUNT (REGION_COUNT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Output side: hold ready low for a drawn number of cycles after each word.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      routes.check_route(out_data);
      if ($urandom_range(0, 63) == 0) recv_calm <= ~recv_calm;
      stall_left <= recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a word moving.", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Distances lean small but reach zero, all ones and the saturation range.
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0:       return ALL_ONES;
      1:       return ALL_ONES - DIST_W'($urandom_range(0, 3));
      2:       return DIST_W'($urandom);
      3:       return 32'h8000_0000 + DIST_W'($urandom_range(0, 255));
      default: return DIST_W'($urandom_range(0, 2000));
    endcase
  endfunction

  // Flags usually name the wanted region, sometimes not.
  function automatic logic [DIST_W-1:0] pick_flags(logic [REGION_W-1:0] region);
    logic [DIST_W-1:0] flags;
    flags = DIST_W'($urandom);
    case ($urandom_range(0, 5))
      0:       flags[region] = 1'b0;
      1:       flags = ALL_ONES;
      2:       flags = DIST_W'(1) << region;
      default: flags[region] = 1'b1;
    endcase
    return flags;
  endfunction

  function automatic logic [IDX_W-1:0] pick_node(bit wide);
    if (wide && $urandom_range(0, 4) == 0) return IDX_W'($urandom);
    return hot_pool[$urandom_range(0, HOT_NODES - 1)];
  endfunction

  function automatic tnafq_in_t noise_word();
    tnafq_in_t w;
    w.kind          = kind_e'($urandom_range(0, 3));
    w.transit_row   = IDX_W'($urandom);
    w.transit_col   = IDX_W'($urandom);
    w.distance      = DIST_W'($urandom);
    w.region_flags  = DIST_W'($urandom);
    w.source_region = REGION_W'($urandom);
    w.target_region = REGION_W'($urandom);
    return w;
  endfunction

  // Present one word after a drawn gap and wait for it to be taken.
  task automatic send_word(tnafq_in_t w);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    routes.take_word(w);
  endtask

  task automatic send_table(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [DIST_W-1:0] length);
    tnafq_in_t w;
    w             = noise_word();
    w.kind        = KIND_TABLE_WR;
    w.transit_row = row;
    w.transit_col = col;
    w.distance    = length;
    send_word(w);
  endtask

  task automatic send_access(kind_e side, logic [IDX_W-1:0] node,
                             logic [DIST_W-1:0] length, logic [DIST_W-1:0] flags);
    tnafq_in_t w;
    w              = noise_word();
    w.kind         = side;
    w.transit_row  = node;
    w.distance     = length;
    w.region_flags = flags;
    send_word(w);
  endtask

  // Fill every table entry the loaded lists could reach, then query.
  task automatic send_query(logic [REGION_W-1:0] src, logic [REGION_W-1:0] tgt);
    tnafq_in_t w;
    for (int i = 0; i < routes.fwd_count; i++)
      for (int j = 0; j < routes.bwd_count; j++)
        if (!routes.known(routes.fwd_list[i].index, routes.bwd_list[j].index))
          send_table(routes.fwd_list[i].index, routes.bwd_list[j].index, pick_distance());
    w               = noise_word();
    w.kind          = KIND_QUERY;
    w.source_region = src;
    w.target_region = tgt;
    send_word(w);
  endtask

  // Take valid down so the last word is not offered again, then wait.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (routes.pending() != 0) @(posedge clk_i);
  endtask

  // Well-formed query: some fresh table entries, both lists interleaved, query.
  task automatic run_route_query(int unsigned min_len, int unsigned max_len, bit wide);
    logic [IDX_W-1:0]    fwd_nodes [$];
    logic [IDX_W-1:0]    bwd_nodes [$];
    logic [REGION_W-1:0] src;
    logic [REGION_W-1:0] tgt;
    int unsigned         nf;
    int unsigned         nb;
    int unsigned         fi;
    int unsigned         bi;
    src = REGION_W'($urandom);
    tgt = REGION_W'($urandom);
    nf  = $urandom_range(min_len, max_len);
    nb  = $urandom_range(min_len, max_len);
    repeat (nf) fwd_nodes = {fwd_nodes, pick_node(wide)};
    repeat (nb) bwd_nodes = {bwd_nodes, pick_node(wide)};
    if (nf * nb <= MAX_ACCESS) begin
      foreach (fwd_nodes[i])
        foreach (bwd_nodes[j])
          if ($urandom_range(0, 2) == 0)
            send_table(fwd_nodes[i], bwd_nodes[j], pick_distance());
    end
    fi = 0;
    bi = 0;
    while (fi < nf || bi < nb) begin
      if (bi >= nb || (fi < nf && $urandom_range(0, 1) == 1)) begin
        send_access(KIND_FWD, fwd_nodes[fi], pick_distance(), pick_flags(tgt));
        fi++;
      end else begin
        send_access(KIND_BWD, bwd_nodes[bi], pick_distance(), pick_flags(src));
        bi++;
      end
    end
    send_query(src, tgt);
  endtask

  // A short burst of fully random words.
  task automatic run_noise();
    tnafq_in_t w;
    repeat ($urandom_range(1, 6)) begin
      w = noise_word();
      if (w.kind == KIND_QUERY) begin
        send_query(w.source_region, w.target_region);
      end else begin
        send_word(w);
      end
    end
  endtask

  // Main sequence: reset, directed cases, random queries, drain and verdict.
  initial begin
    int unsigned pick;
    foreach (hot_pool[k]) hot_pool[k] = IDX_W'($urandom);
    hot_pool[0] = '0;
    hot_pool[1] = '1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty lists give no route.
    send_query(5'd31, 5'd0);
    // Table corners: zero, unreachable, just below all ones and mid-range.
    send_table(8'd0, 8'd255, '0);
    send_table(8'd255, 8'd0, ALL_ONES);
    send_table(8'd255, 8'd255, ALL_ONES - 1);
    send_table(8'd0, 8'd0, 32'h7FFF_FFFF);
    // A sum that saturates never lowers the minimum.
    send_access(KIND_FWD, 8'd255, ALL_ONES, ALL_ONES);
    send_access(KIND_BWD, 8'd255, 32'd5, 32'h8000_0000);
    send_query(5'd31, 5'd31);
    // Zero-length route; the other pair adds up to exactly all ones.
    send_access(KIND_FWD, 8'd0, '0, 32'h0000_0001);
    send_access(KIND_BWD, 8'd255, '0, ALL_ONES);
    send_access(KIND_BWD, 8'd0, 32'h8000_0000, ALL_ONES);
    send_query(5'd5, 5'd0);
    // The only pair crosses an unreachable table entry.
    send_access(KIND_FWD, 8'd255, 32'd3, ALL_ONES);
    send_access(KIND_BWD, 8'd0, 32'd4, ALL_ONES);
    send_query(5'd17, 5'd9);
    // Forward flags do not name the target region.
    send_access(KIND_FWD, 8'd0, 32'd1, '0);
    send_access(KIND_BWD, 8'd255, 32'd1, ALL_ONES);
    send_query(5'd0, 5'd0);
    // Largest access distance pushes the sum past all ones.
    send_access(KIND_FWD, 8'd0, ALL_ONES - 1, ALL_ONES);
    send_access(KIND_BWD, 8'd0, '0, 32'h0000_0002);
    send_query(5'd1, 5'd30);

    // Hold off until every answer is back, then start with full lists.
    wait_drained();
    run_route_query(MAX_ACCESS + 1, MAX_ACCESS + 4, 1'b0);

    while (routes.words_taken < TOTAL_WORDS) begin
      if ($urandom_range(0, 7) == 0) wait_drained();
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        run_noise();
      end else if (pick == 1) begin
        run_route_query(MAX_ACCESS - 2, MAX_ACCESS + 4, 1'b0);
      end else begin
        run_route_query(0, 4, 1'b1);
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drove %0d input words; checked %0d query answers.",
             routes.words_taken, routes.routes_checked);
    $display("Answers with a route: %0d, with dropped entries: %0d, bad words: %0d.",
             routes.routes_found, routes.routes_overflowed, routes.mismatches);
    if (routes.mismatches == 0 && routes.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
